// ===== sv/cwc_pkg.sv =====
// Shared types and constants for the comment and whitespace compressor.
// Used by cwc_front, cwc_back and the top level; no dependencies.
`default_nettype none

package cwc_pkg;

    // Default counter width and queue depth for the top-level parameters
    localparam int COUNT_BITS_DEFAULT  = 16;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    // Width of the reported length field
    localparam int LEN_BITS = 16;

    // Character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_BSLASH = 8'h5C;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_TOKEN,
        MODE_WORD,
        MODE_QUOTE,
        MODE_SLASH,
        MODE_BSLASH,
        MODE_LINEC,
        MODE_BLOCK,
        MODE_BSTAR
    } mode_t;

    // Pending separator codes
    typedef enum logic [1:0] {
        SEP_NONE,
        SEP_SPACE,
        SEP_NL
    } sep_t;

    // One classified input byte: up to three output beats, the final one
    // optionally being the end beat
    typedef struct packed {
        logic [1:0]      cnt;
        logic            is_end;
        logic [2:0][7:0] chars;
    } cmd_t;

endpackage : cwc_pkg

`default_nettype wire

// ===== sv/cwc_front.sv =====
// Front end: accepts input bytes, tracks scan mode and pending separator,
// and turns each byte into a command of output beats. Depends on cwc_pkg.
`default_nettype none

module cwc_front (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic         cfg_wr_data,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire logic [7:0]   s_in_char,
    input  wire logic         q_full,
    output logic              q_push,
    output cwc_pkg::cmd_t     q_cmd
);

    cwc_pkg::mode_t mode_reg, mode_next;
    cwc_pkg::sep_t  sep_reg, sep_next;
    logic           hbb_reg;

    logic           accept;
    logic           blank;
    logic           do_word;
    logic           do_blank;
    logic           do_finish;
    cwc_pkg::cmd_t  cmd;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Classify the byte as blank
    always_comb begin
        blank = (s_in_char inside {[8'd1:8'd32]}) || (s_in_char[7] && hbb_reg);
    end

    // Build the command and next scanner state
    always_comb begin
        mode_next = mode_reg;
        sep_next  = sep_reg;
        cmd       = '0;
        do_word   = 1'b0;
        do_blank  = 1'b0;
        do_finish = 1'b0;

        case (mode_reg)
            cwc_pkg::MODE_WORD: begin
                do_word = 1'b1;
            end
            cwc_pkg::MODE_QUOTE: begin
                if (s_in_char == cwc_pkg::CH_NUL) begin
                    do_finish = 1'b1;
                end else begin
                    cmd.chars[cmd.cnt] = s_in_char;
                    cmd.cnt = cmd.cnt + 2'd1;
                    if (s_in_char == cwc_pkg::CH_QUOTE) begin
                        mode_next = cwc_pkg::MODE_TOKEN;
                    end
                end
            end
            cwc_pkg::MODE_SLASH: begin
                if (s_in_char == cwc_pkg::CH_SLASH) begin
                    sep_next  = cwc_pkg::SEP_SPACE;
                    mode_next = cwc_pkg::MODE_LINEC;
                end else if (s_in_char == cwc_pkg::CH_STAR) begin
                    sep_next  = cwc_pkg::SEP_SPACE;
                    mode_next = cwc_pkg::MODE_BLOCK;
                end else begin
                    // Flush separator, release the held slash, then the byte
                    if (sep_next != cwc_pkg::SEP_NONE) begin
                        cmd.chars[cmd.cnt] = (sep_next == cwc_pkg::SEP_NL) ?
                                             cwc_pkg::CH_LF : cwc_pkg::CH_SPACE;
                        cmd.cnt  = cmd.cnt + 2'd1;
                        sep_next = cwc_pkg::SEP_NONE;
                    end
                    cmd.chars[cmd.cnt] = cwc_pkg::CH_SLASH;
                    cmd.cnt = cmd.cnt + 2'd1;
                    do_word = 1'b1;
                end
            end
            cwc_pkg::MODE_BSLASH: begin
                if (s_in_char == cwc_pkg::CH_LF) begin
                    mode_next = cwc_pkg::MODE_TOKEN;
                end else begin
                    cmd.chars[cmd.cnt] = cwc_pkg::CH_BSLASH;
                    cmd.cnt = cmd.cnt + 2'd1;
                    do_word = 1'b1;
                end
            end
            cwc_pkg::MODE_LINEC: begin
                if (s_in_char == cwc_pkg::CH_NUL) begin
                    do_finish = 1'b1;
                end else if (s_in_char == cwc_pkg::CH_LF) begin
                    do_blank = 1'b1;
                end
            end
            cwc_pkg::MODE_BLOCK: begin
                if (s_in_char == cwc_pkg::CH_NUL) begin
                    do_finish = 1'b1;
                end else if (s_in_char == cwc_pkg::CH_STAR) begin
                    mode_next = cwc_pkg::MODE_BSTAR;
                end
            end
            cwc_pkg::MODE_BSTAR: begin
                if (s_in_char == cwc_pkg::CH_NUL) begin
                    do_finish = 1'b1;
                end else if (s_in_char == cwc_pkg::CH_SLASH) begin
                    mode_next = cwc_pkg::MODE_TOKEN;
                end else if (s_in_char != cwc_pkg::CH_STAR) begin
                    mode_next = cwc_pkg::MODE_BLOCK;
                end
            end
            default: begin
                // Token start
                if (s_in_char == cwc_pkg::CH_NUL) begin
                    do_finish = 1'b1;
                end else if (blank) begin
                    do_blank = 1'b1;
                end else if (s_in_char == cwc_pkg::CH_SLASH) begin
                    mode_next = cwc_pkg::MODE_SLASH;
                end else begin
                    if (sep_next != cwc_pkg::SEP_NONE) begin
                        cmd.chars[cmd.cnt] = (sep_next == cwc_pkg::SEP_NL) ?
                                             cwc_pkg::CH_LF : cwc_pkg::CH_SPACE;
                        cmd.cnt  = cmd.cnt + 2'd1;
                        sep_next = cwc_pkg::SEP_NONE;
                    end
                    if (s_in_char == cwc_pkg::CH_BSLASH) begin
                        mode_next = cwc_pkg::MODE_BSLASH;
                    end else begin
                        cmd.chars[cmd.cnt] = s_in_char;
                        cmd.cnt   = cmd.cnt + 2'd1;
                        mode_next = (s_in_char == cwc_pkg::CH_QUOTE) ?
                                    cwc_pkg::MODE_QUOTE : cwc_pkg::MODE_WORD;
                    end
                end
            end
        endcase

        // Handle the byte as part of a word
        if (do_word) begin
            if (s_in_char == cwc_pkg::CH_NUL) begin
                do_finish = 1'b1;
            end else if (blank) begin
                do_blank = 1'b1;
            end else begin
                cmd.chars[cmd.cnt] = s_in_char;
                cmd.cnt   = cmd.cnt + 2'd1;
                mode_next = cwc_pkg::MODE_WORD;
            end
        end

        // Fold a blank into the pending separator
        if (do_blank) begin
            if (s_in_char == cwc_pkg::CH_LF) begin
                sep_next = cwc_pkg::SEP_NL;
            end else if (sep_next == cwc_pkg::SEP_NONE) begin
                sep_next = cwc_pkg::SEP_SPACE;
            end
            mode_next = cwc_pkg::MODE_TOKEN;
        end

        // Append the end beat and return to reset state
        if (do_finish) begin
            cmd.chars[cmd.cnt] = cwc_pkg::CH_NUL;
            cmd.cnt    = cmd.cnt + 2'd1;
            cmd.is_end = 1'b1;
            mode_next  = cwc_pkg::MODE_TOKEN;
            sep_next   = cwc_pkg::SEP_NONE;
        end
    end

    assign q_push = accept && (cmd.cnt != 2'd0);
    assign q_cmd  = cmd;

    // Advance scanner state on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= cwc_pkg::MODE_TOKEN;
            sep_reg  <= cwc_pkg::SEP_NONE;
        end else if (accept) begin
            mode_reg <= mode_next;
            sep_reg  <= sep_next;
        end
    end

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hbb_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            hbb_reg <= cfg_wr_data;
        end
    end

endmodule : cwc_front

`default_nettype wire

// ===== sv/cwc_queue.sv =====
// Short register queue of commands between front and back end.
// Generic in width and depth; no package dependencies.
`default_nettype none

module cwc_queue #(
    parameter int WIDTH = 27,
    parameter int DEPTH = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output logic      [WIDTH-1:0] head_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_BITS-1:0] fill_reg;
    logic                do_push, do_pop;

    assign full       = (fill_reg == CNT_BITS'(DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_data  = mem_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    // Store entries
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    // Advance pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

endmodule : cwc_queue

`default_nettype wire

// ===== sv/cwc_back.sv =====
// Back end: walks each queued command one beat at a time, keeps the
// saturating byte count and drives the registered output. Depends on cwc_pkg.
`default_nettype none

module cwc_back #(
    parameter int COUNT_BITS = cwc_pkg::COUNT_BITS_DEFAULT
) (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      q_valid,
    input  wire cwc_pkg::cmd_t             q_cmd,
    output logic                           q_pop,
    output logic                           m_valid,
    input  wire logic                      m_ready,
    output logic [7:0]                     m_out_char,
    output logic                           m_is_end,
    output logic [cwc_pkg::LEN_BITS-1:0]   m_out_length,
    output logic                           m_last
);

    logic                          valid_reg, valid_next;
    logic [7:0]                    char_reg;
    logic                          end_reg;
    logic [cwc_pkg::LEN_BITS-1:0]  len_reg, len_next;
    logic                          last_reg;
    logic [COUNT_BITS-1:0]         count_reg, count_next, count_inc;
    logic [1:0]                    idx_reg, idx_next;
    logic                          load;
    logic                          last_beat;
    logic                          end_beat;
    logic [31:0]                   len_wide;

    assign last_beat = (idx_reg == (q_cmd.cnt - 2'd1));
    assign end_beat  = q_cmd.is_end && last_beat;
    assign load      = q_valid && (!valid_reg || m_ready);
    assign q_pop     = load && last_beat;
    assign count_inc = (count_reg == '1) ? count_reg : count_reg + 1'b1;

    // Next count, reported length and beat index
    always_comb begin
        count_next = count_reg;
        idx_next   = idx_reg;
        len_wide   = 32'(count_reg);
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = last_beat ? 2'd0 : idx_reg + 2'd1;
            if (end_beat) begin
                count_next = '0;
            end else begin
                count_next = count_inc;
                len_wide   = 32'(count_inc);
            end
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
        len_next = (len_wide > 32'h0000_FFFF) ? '1 : len_wide[cwc_pkg::LEN_BITS-1:0];
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            count_reg <= '0;
            idx_reg   <= '0;
        end else begin
            valid_reg <= valid_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
        end
    end

    // Output beat payload
    always_ff @(posedge aclk) begin
        if (load) begin
            char_reg <= q_cmd.chars[idx_reg];
            end_reg  <= end_beat;
            len_reg  <= len_next;
            last_reg <= last_beat;
        end
    end

    assign m_valid      = valid_reg;
    assign m_out_char   = char_reg;
    assign m_is_end     = end_reg;
    assign m_out_length = len_reg;
    assign m_last       = last_reg;

endmodule : cwc_back

`default_nettype wire

// ===== sv/comment_whitespace_compressor_core.sv =====
// Top level of the comment and whitespace compressor: front end, command
// queue and back end. Depends on cwc_pkg, cwc_front, cwc_queue, cwc_back.
//
// Accepts one source byte per cycle while the command queue has room and
// emits one result beat per cycle while the receiver is ready. A byte may
// produce no output, or up to three beats (separator, held character, and
// the byte itself or the end beat), which leave through the single output
// register one after another. The queue holds QUEUE_DEPTH commands, letting
// input continue while the output is stalled or busy with a multi-beat
// command. No clearing pass is needed after reset.
`default_nettype none

module comment_whitespace_compressor_core #(
    parameter int COUNT_BITS  = cwc_pkg::COUNT_BITS_DEFAULT,
    parameter int QUEUE_DEPTH = cwc_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic                     cfg_wr_data,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [7:0]               s_in_char,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [7:0]                    m_out_char,
    output logic                          m_is_end,
    output logic [cwc_pkg::LEN_BITS-1:0]  m_out_length,
    output logic                          m_last
);

    localparam int CMD_BITS = $bits(cwc_pkg::cmd_t);

    logic           q_full;
    logic           q_push;
    logic           q_pop;
    logic           q_valid;
    cwc_pkg::cmd_t  push_cmd;
    cwc_pkg::cmd_t  head_cmd;

    // Classify incoming bytes
    cwc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_in_char   (s_in_char),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_cmd       (push_cmd)
    );

    // Decouple front and back
    cwc_queue #(
        .WIDTH (CMD_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_data  (push_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (head_cmd)
    );

    // Emit result beats
    cwc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_cmd        (head_cmd),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_is_end     (m_is_end),
        .m_out_length (m_out_length),
        .m_last       (m_last)
    );

endmodule : comment_whitespace_compressor_core

`default_nettype wire

// ===== sim/comment_whitespace_compressor_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for comment_whitespace_compressor_core: streams text bytes,
// predicts the minified beats in-line and compares every output beat.
// Depends on cwc_pkg and the compressor RTL.

module comment_whitespace_compressor_core_test;

    localparam longint unsigned COUNT_MAX = (64'd1 << cwc_pkg::COUNT_BITS_DEFAULT) - 1;
    localparam longint unsigned LEN_MAX   = (64'd1 << cwc_pkg::LEN_BITS) - 1;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = cwc_pkg::QUEUE_DEPTH_DEFAULT + 8;
    localparam int RANDOM_BYTES  = 90;
    localparam logic [7:0] CH_TAB = 8'h09;

    typedef struct {
        logic [7:0]                   ch;
        logic                         is_end;
        logic [cwc_pkg::LEN_BITS-1:0] len;
        logic                         last;
    } out_beat_t;

    typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN} rx_style_t;

    typedef enum int {
        TOK_WORD, TOK_BLANKS, TOK_LINE_CMT, TOK_BLOCK_CMT, TOK_QUOTE,
        TOK_BS_NL, TOK_SLASH_WORD, TOK_BS_WORD, TOK_NOISE
    } tok_kind_t;

    logic                         aclk        = 1'b0;
    logic                         aresetn     = 1'b0;
    logic                         cfg_wr_en   = 1'b0;
    logic                         cfg_wr_data = 1'b0;
    logic                         s_valid     = 1'b0;
    logic [7:0]                   s_in_char   = 8'h00;
    logic                         m_ready     = 1'b0;
    logic                         s_ready;
    logic                         m_valid;
    logic [7:0]                   m_out_char;
    logic                         m_is_end;
    logic [cwc_pkg::LEN_BITS-1:0] m_out_length;
    logic                         m_last;

    // Predictor state
    cwc_pkg::mode_t  scan_mode_q = cwc_pkg::MODE_TOKEN;
    cwc_pkg::sep_t   sep_q       = cwc_pkg::SEP_NONE;
    longint unsigned out_count   = 0;
    logic            high_blank  = 1'b0;
    out_beat_t       staged[3];
    int              byte_beats;
    out_beat_t       minified_q[$];

    // Stimulus control
    bit          tx_gaps    = 1'b0;
    int          burst_left = 0;
    int          sent_count = 0;
    rx_style_t   rx_style   = RX_OPEN;
    int          rx_hold    = 0;
    int unsigned rx_tick    = 0;
    int unsigned cycle_count = 0;
    int          errors     = 0;

    always #2 aclk = ~aclk;

    comment_whitespace_compressor_core i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_char    (s_in_char),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_char   (m_out_char),
        .m_is_end     (m_is_end),
        .m_out_length (m_out_length),
        .m_last       (m_last)
    );

    // ---------------------------------------------------------------- predictor

    function automatic logic blank_byte(logic [7:0] c);
        return (c >= 8'd1 && c <= 8'd32) || (c >= 8'd128 && high_blank);
    endfunction

    function automatic logic [cwc_pkg::LEN_BITS-1:0] reported_len();
        return cwc_pkg::LEN_BITS'(out_count > LEN_MAX ? LEN_MAX : out_count);
    endfunction

    function automatic void emit_char(logic [7:0] c);
        if (out_count < COUNT_MAX) out_count++;
        staged[byte_beats] = '{ch: c, is_end: 1'b0, len: reported_len(), last: 1'b0};
        byte_beats++;
    endfunction

    // Emit the end beat and rewind for the next string
    function automatic void end_string();
        staged[byte_beats] = '{ch: cwc_pkg::CH_NUL, is_end: 1'b1, len: reported_len(),
                               last: 1'b0};
        byte_beats++;
        scan_mode_q = cwc_pkg::MODE_TOKEN;
        sep_q       = cwc_pkg::SEP_NONE;
        out_count   = 0;
    endfunction

    function automatic void take_blank(logic [7:0] c);
        if (c == cwc_pkg::CH_LF) sep_q = cwc_pkg::SEP_NL;
        else if (sep_q == cwc_pkg::SEP_NONE) sep_q = cwc_pkg::SEP_SPACE;
        scan_mode_q = cwc_pkg::MODE_TOKEN;
    endfunction

    function automatic void flush_sep();
        if (sep_q != cwc_pkg::SEP_NONE) begin
            emit_char(sep_q == cwc_pkg::SEP_NL ? cwc_pkg::CH_LF : cwc_pkg::CH_SPACE);
            sep_q = cwc_pkg::SEP_NONE;
        end
    endfunction

    function automatic void word_byte(logic [7:0] c);
        if (c == cwc_pkg::CH_NUL) end_string();
        else if (blank_byte(c)) take_blank(c);
        else begin
            emit_char(c);
            scan_mode_q = cwc_pkg::MODE_WORD;
        end
    endfunction

    // Advance the scanner by one accepted byte and queue the beats it causes
    function automatic void minify_byte(logic [7:0] c);
        byte_beats = 0;
        case (scan_mode_q)
            cwc_pkg::MODE_WORD: word_byte(c);
            cwc_pkg::MODE_QUOTE: begin
                if (c == cwc_pkg::CH_NUL) end_string();
                else begin
                    emit_char(c);
                    if (c == cwc_pkg::CH_QUOTE) scan_mode_q = cwc_pkg::MODE_TOKEN;
                end
            end
            cwc_pkg::MODE_SLASH: begin
                if (c == cwc_pkg::CH_SLASH) begin
                    sep_q = cwc_pkg::SEP_SPACE;
                    scan_mode_q = cwc_pkg::MODE_LINEC;
                end else if (c == cwc_pkg::CH_STAR) begin
                    sep_q = cwc_pkg::SEP_SPACE;
                    scan_mode_q = cwc_pkg::MODE_BLOCK;
                end else begin
                    flush_sep();
                    emit_char(cwc_pkg::CH_SLASH);
                    word_byte(c);
                end
            end
            cwc_pkg::MODE_BSLASH: begin
                if (c == cwc_pkg::CH_LF) scan_mode_q = cwc_pkg::MODE_TOKEN;
                else begin
                    emit_char(cwc_pkg::CH_BSLASH);
                    word_byte(c);
                end
            end
            cwc_pkg::MODE_LINEC: begin
                if (c == cwc_pkg::CH_NUL) end_string();
                else if (c == cwc_pkg::CH_LF) take_blank(c);
            end
            cwc_pkg::MODE_BLOCK: begin
                if (c == cwc_pkg::CH_NUL) end_string();
                else if (c == cwc_pkg::CH_STAR) scan_mode_q = cwc_pkg::MODE_BSTAR;
            end
            cwc_pkg::MODE_BSTAR: begin
                if (c == cwc_pkg::CH_NUL) end_string();
                else if (c == cwc_pkg::CH_SLASH) scan_mode_q = cwc_pkg::MODE_TOKEN;
                else if (c != cwc_pkg::CH_STAR) scan_mode_q = cwc_pkg::MODE_BLOCK;
            end
            default: begin
                if (c == cwc_pkg::CH_NUL) end_string();
                else if (blank_byte(c)) take_blank(c);
                else if (c == cwc_pkg::CH_SLASH) scan_mode_q = cwc_pkg::MODE_SLASH;
                else if (c == cwc_pkg::CH_BSLASH) begin
                    flush_sep();
                    scan_mode_q = cwc_pkg::MODE_BSLASH;
                end else if (c == cwc_pkg::CH_QUOTE) begin
                    flush_sep();
                    emit_char(cwc_pkg::CH_QUOTE);
                    scan_mode_q = cwc_pkg::MODE_QUOTE;
                end else begin
                    flush_sep();
                    emit_char(c);
                    scan_mode_q = cwc_pkg::MODE_WORD;
                end
            end
        endcase
        if (byte_beats > 0) staged[byte_beats-1].last = 1'b1;
        for (int i = 0; i < byte_beats; i++) minified_q.push_back(staged[i]);
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, name, exp_v, act_v);
        end
    endfunction

    // Compare each output beat with the oldest predicted beat
    always @(posedge aclk) begin : check_beats
        out_beat_t exp_b;
        if (aresetn && m_valid && m_ready) begin
            if (minified_q.size() == 0) begin
                errors++;
                $display("%0t: beat expected none got char %0h end %0b len %0d last %0b",
                         $time, m_out_char, m_is_end, m_out_length, m_last);
            end else begin
                exp_b = minified_q.pop_front();
                check_field("out_char", exp_b.ch, m_out_char);
                check_field("is_end", exp_b.is_end, m_is_end);
                check_field("out_length", exp_b.len, m_out_length);
                check_field("last", exp_b.last, m_last);
            end
        end
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: long hold-off on request, otherwise the selected stall pattern
    always @(posedge aclk) begin
        rx_tick++;
        if (rx_hold > 0) begin
            rx_hold--;
            m_ready <= 1'b0;
        end else begin
            case (rx_style)
                RX_OPEN:   m_ready <= 1'b1;
                RX_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                default:   m_ready <= ((rx_tick % 8) >= 3);
            endcase
        end
    end

    // ---------------------------------------------------------------- sender

    // Offer one byte, hold it until accepted, then predict its beats
    task automatic send_byte(logic [7:0] c);
        int gap;
        if (tx_gaps && burst_left == 0) begin
            gap = $urandom_range(0, 5);
            burst_left = $urandom_range(1, 16);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        if (burst_left > 0) burst_left--;
        s_valid   <= 1'b1;
        s_in_char <= c;
        do @(posedge aclk); while (!s_ready);
        sent_count++;
        minify_byte(c);
    endtask

    task automatic send_text(string txt);
        for (int i = 0; i < txt.len(); i++) send_byte(txt[i]);
        send_byte(cwc_pkg::CH_NUL);
    endtask

    // Stop offering and wait until every predicted beat has come out
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (minified_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_high_blank(logic v);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        high_blank  = v;
    endtask

    function automatic logic [7:0] random_byte_except(logic [7:0] avoid);
        logic [7:0] c;
        do c = 8'($urandom_range(1, 255)); while (c == avoid);
        return c;
    endfunction

    // Send one token of source text; comments and quotes sometimes stay open
    task automatic send_token(tok_kind_t kind);
        int n;
        logic [7:0] blanks[4];
        n = $urandom_range(0, 6);
        blanks = '{cwc_pkg::CH_SPACE, CH_TAB, cwc_pkg::CH_LF, 8'h00};
        case (kind)
            TOK_WORD: repeat (n + 1) send_byte(8'($urandom_range(33, 255)));
            TOK_BLANKS: begin
                repeat ((n % 3) + 1) begin
                    blanks[3] = 8'($urandom_range(1, 32));
                    send_byte(blanks[$urandom_range(0, 3)]);
                end
            end
            TOK_LINE_CMT: begin
                send_byte(cwc_pkg::CH_SLASH);
                send_byte(cwc_pkg::CH_SLASH);
                repeat (n) send_byte(random_byte_except(cwc_pkg::CH_LF));
                if ($urandom_range(0, 9) < 7) send_byte(cwc_pkg::CH_LF);
            end
            TOK_BLOCK_CMT: begin
                send_byte(cwc_pkg::CH_SLASH);
                send_byte(cwc_pkg::CH_STAR);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0) send_byte(cwc_pkg::CH_STAR);
                    else send_byte(random_byte_except(cwc_pkg::CH_NUL));
                end
                if ($urandom_range(0, 5) != 0) begin
                    send_byte(cwc_pkg::CH_STAR);
                    send_byte(cwc_pkg::CH_SLASH);
                end
            end
            TOK_QUOTE: begin
                send_byte(cwc_pkg::CH_QUOTE);
                repeat (n) send_byte(random_byte_except(cwc_pkg::CH_QUOTE));
                if ($urandom_range(0, 5) != 0) send_byte(cwc_pkg::CH_QUOTE);
            end
            TOK_BS_NL: begin
                send_byte(cwc_pkg::CH_BSLASH);
                send_byte(cwc_pkg::CH_LF);
            end
            TOK_SLASH_WORD: begin
                send_byte(cwc_pkg::CH_SLASH);
                send_byte(random_byte_except(cwc_pkg::CH_NUL));
            end
            TOK_BS_WORD: begin
                send_byte(cwc_pkg::CH_BSLASH);
                send_byte(random_byte_except(cwc_pkg::CH_NUL));
            end
            default: send_byte(random_byte_except(cwc_pkg::CH_NUL));
        endcase
    endtask

    // ---------------------------------------------------------------- tests

    // Blank runs, comments, held slash and backslash, quotes, flush at end
    task automatic test_directed();
        rx_style = RX_RANDOM;
        tx_gaps  = 1'b1;
        send_text(" a\n/**/\\\nb /");
        send_text("\"q \"/x \\y \\");
        send_text("//c");
        wait_drained();
    endtask

    // High bytes as word bytes and as blanks, both register values
    task automatic test_high_bytes();
        logic [7:0] seq[6];
        // a, 0x80, b, 0xFF, 0x7F, terminator
        seq = '{8'h61, 8'h80, 8'h62, 8'hFF, 8'h7F, cwc_pkg::CH_NUL};
        rx_style = RX_PATTERN;
        write_high_blank(1'b1);
        foreach (seq[i]) send_byte(seq[i]);
        write_high_blank(1'b0);
        foreach (seq[i]) send_byte(seq[i]);
        wait_drained();
    endtask

    // Hold the receiver off so the queue fills and the input stalls
    task automatic test_backpressure();
        rx_style = RX_OPEN;
        tx_gaps  = 1'b0;
        rx_hold  = 300;
        repeat (40) send_byte(8'($urandom_range(32, 126)));
        send_byte(cwc_pkg::CH_NUL);
        wait_drained();
    endtask

    // Random strings built from tokens, with config and idling shuffled
    task automatic test_random_text();
        int start;
        int n_tok;
        start   = sent_count;
        tx_gaps = 1'b1;
        while (sent_count - start < RANDOM_BYTES) begin
            if ($urandom_range(0, 4) == 0) write_high_blank(1'($urandom_range(0, 1)));
            rx_style = rx_style_t'($urandom_range(0, 2));
            n_tok = $urandom_range(1, 8);
            repeat (n_tok) send_token(tok_kind_t'($urandom_range(0, 8)));
            send_byte(cwc_pkg::CH_NUL);
        end
        wait_drained();
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_high_bytes();
        test_backpressure();
        test_random_text();
        wait_drained();
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/cwc_pkg.sv
sv/cwc_front.sv
sv/cwc_queue.sv
sv/cwc_back.sv
sv/comment_whitespace_compressor_core.sv
sim/comment_whitespace_compressor_core_test.sv
